>>> rtl/compensated_float_summation_unit_assert.svh
// Assertion macros used by the top RTL file of the summation unit.
`ifndef COMPENSATED_FLOAT_SUMMATION_UNIT_ASSERT_SVH
`define COMPENSATED_FLOAT_SUMMATION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define CFSU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define CFSU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cfsu_pkg.sv
`default_nettype none
package cfsu_pkg;

    localparam int ADDR_W  = 3;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic REG_MODE = 1'b0;

    localparam logic MODE_COMP  = 1'b0;
    localparam logic MODE_PLAIN = 1'b1;

    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
    localparam logic [30:0] FP_INF  = 31'h7F80_0000;

    typedef struct packed {
        logic [31:0] addend;
        logic        is_last;
        logic        mode;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_W,
        ST_TU,
        ST_TL,
        ST_S,
        ST_E,
        ST_PLAIN,
        ST_OUT
    } step_t;

    // IEEE binary32 add, round to nearest even, canonical quiet NaN.
    function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
        logic [30:0] ax;
        logic [30:0] ay;
        logic [30:0] tmp;
        logic        sx;
        logic        sy;
        logic        tsg;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [26:0] mx;
        logic [26:0] my;
        logic [26:0] mask;
        logic [27:0] m;
        logic [9:0]  e;
        logic [4:0]  lz;
        logic [9:0]  sh;
        logic [2:0]  rem;
        logic [24:0] mr;
        logic [7:0]  field;
        ax = x[30:0];
        ay = y[30:0];
        sx = x[31];
        sy = y[31];
        if (ax > FP_INF || ay > FP_INF) begin
            return FP_QNAN;
        end
        if (ax == FP_INF || ay == FP_INF) begin
            if (ax == FP_INF && ay == FP_INF && sx != sy) begin
                return FP_QNAN;
            end
            return (ax == FP_INF) ? x : y;
        end
        if (ax == 31'd0 && ay == 31'd0) begin
            return {sx & sy, 31'd0};
        end
        if (ax == 31'd0) begin
            return y;
        end
        if (ay == 31'd0) begin
            return x;
        end
        if (ay > ax) begin
            tmp = ax;
            ax  = ay;
            ay  = tmp;
            tsg = sx;
            sx  = sy;
            sy  = tsg;
        end
        ex = (ax[30:23] == 8'd0) ? 8'd1 : ax[30:23];
        ey = (ay[30:23] == 8'd0) ? 8'd1 : ay[30:23];
        mx = {ax[30:23] != 8'd0, ax[22:0], 3'b000};
        my = {ay[30:23] != 8'd0, ay[22:0], 3'b000};
        d  = ex - ey;
        if (d >= 8'd27) begin
            my = {26'd0, my != 27'd0};
        end else if (d != 8'd0) begin
            mask = (27'd1 << d[4:0]) - 27'd1;
            my   = (my >> d[4:0]) | {26'd0, (my & mask) != 27'd0};
        end
        e = {2'b00, ex};
        if (sx == sy) begin
            m = {1'b0, mx} + {1'b0, my};
            if (m[27]) begin
                m = {1'b0, m[27:1]} | {27'd0, m[0]};
                e = e + 10'd1;
            end
        end else begin
            m = {1'b0, mx} - {1'b0, my};
            if (m == 28'd0) begin
                return 32'd0;
            end
            lz = 5'd27;
            for (int i = 0; i < 27; i++) begin
                if (m[i]) begin
                    lz = 5'(26 - i);
                end
            end
            sh = ({5'd0, lz} < (e - 10'd1)) ? {5'd0, lz} : (e - 10'd1);
            m  = m << sh[4:0];
            e  = e - sh;
        end
        rem = m[2:0];
        mr  = {1'b0, m[26:3]};
        if (rem > 3'd4 || (rem == 3'd4 && mr[0])) begin
            mr = mr + 25'd1;
        end
        if (mr[24]) begin
            mr = mr >> 1;
            e  = e + 10'd1;
        end
        if (e >= 10'd255) begin
            return {sx, FP_INF};
        end
        field = mr[23] ? e[7:0] : 8'd0;
        return {sx, field, mr[22:0]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/cfsu_front.sv
`default_nettype none
module cfsu_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cfsu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [31:0]                 addend,
    input  wire logic                        is_last,
    output logic                             q_valid,
    output cfsu_pkg::item_t                  q_item,
    input  wire logic                        q_pop
);
    import cfsu_pkg::*;

    logic                mode_reg;
    item_t               q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  cnt_reg;
    logic                push;
    logic                pop;
    logic                cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MODE);
    assign prdata = (paddr[ADDR_W-1] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    assign in_stall = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg   <= MODE_COMP;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_wr) begin
                mode_reg <= pwdata[0];
            end
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The mode in force at acceptance travels with the item.
    always_ff @(posedge clk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= '{addend: addend, is_last: is_last, mode: mode_reg};
        end
    end

endmodule
`default_nettype wire

>>> rtl/cfsu_back.sv
`default_nettype none
module cfsu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  cfsu_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [31:0]          total
);
    import cfsu_pkg::*;

    step_t       state_reg;
    step_t       state_next;
    item_t       cur_reg;
    logic [31:0] sum_reg;
    logic [31:0] err_reg;
    logic [31:0] w_reg;
    logic [31:0] tu_reg;
    logic [31:0] tl_reg;
    logic [31:0] total_reg;
    logic        out_valid_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] add_res;
    logic        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign total     = total_reg;
    assign add_res   = fp_add(op_a, op_b);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = (q_item.mode == MODE_PLAIN) ? ST_PLAIN : ST_W;
                end
            end
            ST_W:     state_next = ST_TU;
            ST_TU:    state_next = ST_TL;
            ST_TL:    state_next = ST_S;
            ST_S:     state_next = ST_E;
            ST_E:     state_next = cur_reg.is_last ? ST_OUT : ST_IDLE;
            ST_PLAIN: state_next = cur_reg.is_last ? ST_OUT : ST_IDLE;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop = 1'b0;
        op_a  = sum_reg;
        op_b  = cur_reg.addend;
        case (state_reg)
            ST_IDLE:  q_pop = q_valid;
            ST_W:     op_b  = cur_reg.addend;
            ST_TU:    begin op_a = w_reg;          op_b = sum_reg ^ 32'h8000_0000; end
            ST_TL:    begin op_a = cur_reg.addend; op_b = tu_reg ^ 32'h8000_0000;  end
            ST_S:     op_b  = tu_reg;
            ST_E:     begin op_a = err_reg;        op_b = tl_reg;                  end
            ST_PLAIN: op_b  = cur_reg.addend;
            ST_OUT:   op_b  = err_reg;
            default:  q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= 32'd0;
            err_reg       <= 32'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_S, ST_PLAIN: sum_reg <= add_res;
                ST_E:           err_reg <= add_res;
                ST_OUT: begin
                    if (out_free) begin
                        sum_reg       <= 32'd0;
                        err_reg       <= 32'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            cur_reg <= q_item;
        end
        case (state_reg)
            ST_W:   w_reg  <= add_res;
            ST_TU:  tu_reg <= add_res;
            ST_TL:  tl_reg <= add_res;
            ST_OUT: begin
                if (out_free) begin
                    total_reg <= add_res;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/compensated_float_summation_unit.sv
// Compensated binary32 summation unit.
// Addends arrive on the input channel (in_valid, in_stall, addend, is_last); a
// request is taken at a clock edge with in_valid high and in_stall low. The
// run total leaves on the output channel (out_valid, out_stall, total), one
// request per addend marked is_last, holding steady while out_stall is high.
// The mode register (APB offset 0) selects compensated (0) or plain (1)
// summation; the mode in force when an addend is taken applies to it.
// A compensated addend occupies the shared adder for five dependent additions
// plus the queue pop, a plain one for one addition plus the pop; the single
// binary32 adder in the back end serialises them, so one addend finishes
// before the next is popped. A last addend adds a step to form sum plus
// error, which waits while a previous total is still stalled on the output.
// A two-entry request queue lets the front keep accepting while the back
// works or waits on a stalled output. Reset clears both accumulators to +0,
// the mode to compensated, and empties the queue and output register.
`default_nettype none
module compensated_float_summation_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cfsu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [31:0]                 addend,
    input  wire logic                        is_last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [31:0]                 total
);
    import cfsu_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    assign pready = 1'b1;

    // Front end: register file and request queue.
    cfsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .addend   (addend),
        .is_last  (is_last),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back end: sequencer around one binary32 adder and the accumulators.
    cfsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .total     (total)
    );

`include "compensated_float_summation_unit_assert.svh"

    // The back end never pops an empty queue.
    `CFSU_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
    // An accepted request is visible to the back end on the next cycle.
    `CFSU_ASSERT_NEXT(a_push_visible, in_valid && !in_stall, q_valid, "accepted request lost")

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Adds binary32 values bit by bit: round to nearest even, canonical quiet NaN.
function automatic logic [31:0] sum_fp32(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] big;
    logic [31:0] lit;
    logic [30:0] mag_b;
    logic [30:0] mag_l;
    logic [7:0]  exp_b;
    logic [7:0]  exp_l;
    logic [31:0] man_b;
    logic [31:0] man_l;
    logic [31:0] exp_gap;
    logic [31:0] acc;
    logic [2:0]  guard;
    int          expo;
    big   = a_in;
    lit   = b_in;
    mag_b = big[30:0];
    mag_l = lit[30:0];
    if (mag_b > 31'h7F80_0000 || mag_l > 31'h7F80_0000)
        return 32'h7FC0_0000;
    if (mag_b == 31'h7F80_0000 || mag_l == 31'h7F80_0000)
    begin
        if (mag_b == mag_l && big[31] != lit[31])
            return 32'h7FC0_0000;
        return (mag_b == 31'h7F80_0000) ? big : lit;
    end
    if (mag_b == 0 && mag_l == 0)
        return {big[31] & lit[31], 31'd0};
    if (mag_b == 0)
        return lit;
    if (mag_l == 0)
        return big;
    if (mag_l > mag_b)
    begin
        big   = b_in;
        lit   = a_in;
        mag_b = big[30:0];
        mag_l = lit[30:0];
    end
    exp_b = (mag_b[30:23] == 0) ? 8'd1 : mag_b[30:23];
    exp_l = (mag_l[30:23] == 0) ? 8'd1 : mag_l[30:23];
    man_b = {5'd0, mag_b[30:23] != 0, mag_b[22:0], 3'b000};
    man_l = {5'd0, mag_l[30:23] != 0, mag_l[22:0], 3'b000};
    exp_gap = {24'd0, exp_b - exp_l};
    if (exp_gap >= 31)
        man_l = {31'd0, man_l != 0};
    else if (exp_gap > 0)
        man_l = (man_l >> exp_gap) | {31'd0, (man_l & ((32'd1 << exp_gap) - 1)) != 0};
    expo = exp_b;
    if (big[31] == lit[31])
    begin
        acc = man_b + man_l;
        if (acc >= (32'd1 << 27))
        begin
            acc = (acc >> 1) | (acc & 1);
            expo++;
        end
    end
    else
    begin
        acc = man_b - man_l;
        if (acc == 0)
            return 32'd0;
        while (acc < (32'd1 << 26) && expo > 1)
        begin
            acc = acc << 1;
            expo--;
        end
    end
    guard = acc[2:0];
    acc   = acc >> 3;
    if (guard > 4 || (guard == 4 && acc[0]))
        acc++;
    if (acc >= (32'd1 << 24))
    begin
        acc = acc >> 1;
        expo++;
    end
    if (expo >= 255)
        return {big[31], 31'h7F80_0000};
    return {big[31], (acc < (32'd1 << 23)) ? 8'd0 : 8'(expo), acc[22:0]};
endfunction

// Keeps a copy of both accumulators and the queue of expected run totals.
class total_scoreboard;
    logic [31:0] run_sum;
    logic [31:0] err_sum;
    logic        sum_mode;
    logic [31:0] totals_due[$];
    int          mismatches;
    int          totals_seen;

    function new();
        run_sum     = 0;
        err_sum     = 0;
        sum_mode    = cfsu_pkg::MODE_COMP;
        mismatches  = 0;
        totals_seen = 0;
    endfunction

    function void note_addend(logic [31:0] val, logic fin);
        logic [31:0] w_val;
        logic [31:0] t_up;
        logic [31:0] t_lo;
        if (sum_mode == cfsu_pkg::MODE_COMP)
        begin
            w_val   = sum_fp32(run_sum, val);
            t_up    = sum_fp32(w_val, run_sum ^ 32'h8000_0000);
            t_lo    = sum_fp32(val, t_up ^ 32'h8000_0000);
            run_sum = sum_fp32(run_sum, t_up);
            err_sum = sum_fp32(err_sum, t_lo);
        end
        else
            run_sum = sum_fp32(run_sum, val);
        if (fin)
        begin
            totals_due.push_back(sum_fp32(run_sum, err_sum));
            run_sum = 0;
            err_sum = 0;
        end
    endfunction

    function void check_total(logic [31:0] got);
        logic [31:0] want;
        totals_seen++;
        if (totals_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected total %h", got);
            return;
        end
        want = totals_due.pop_front();
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: total expected %h actual %h", want, got);
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [cfsu_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] addend;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] total;

    total_scoreboard board;
    int  idle_cycles;
    bit  timed_out;
    bit  hold_output;   // set while the receiver is held off on purpose
    int  sent_count;

    compensated_float_summation_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .addend(addend), .is_last(is_last),
        .out_valid(out_valid), .out_stall(out_stall), .total(total)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Setup and access phase; the register takes the value at the access edge.
    task automatic write_mode(input logic val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= cfsu_pkg::ADDR_W'(4 * cfsu_pkg::REG_MODE);
        pwdata  <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.sum_mode = val;
    endtask

    // Offers one request after a random gap, holding it until it is taken.
    // With no gap the next request follows the previous one directly.
    task automatic send_addend(input logic [31:0] val, input logic fin);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        addend   <= val;
        is_last  <= fin;
        do
            @(posedge clk);
        while (in_stall);
        board.note_addend(val, fin);
        sent_count++;
    endtask

    // Withdraws the input, waits until every total has come back, then lets
    // the back end finish any addends still queued.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.totals_due.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // Random binary32 operand that favors nearby exponents, zeros and specials.
    function automatic logic [31:0] pick_value();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: raw[30:23] = 8'hFF;
            1: raw[30:23] = 8'h00;
            2: raw[30:0]  = 31'd0;
            3, 4, 5, 6: raw[30:23] = 8'd120 + 8'($urandom_range(0, 16));
            7: raw[30:23] = 8'd245 + 8'($urandom_range(0, 9));
            default: ;
        endcase
        return raw;
    endfunction

    // Receiver: random stall per request, plus one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                board.check_total(total);
            if (hold_output)
                out_stall <= 1'b1;
            else if (out_valid && !out_stall)
                out_stall <= ($urandom_range(0, 7) != 0) && ($urandom_range(0, 2) != 0);
            else if (out_stall)
                out_stall <= ($urandom_range(0, 7) != 0) && ($urandom_range(0, 2) != 0);
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: counts cycles in which no request moves on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    // Long stall on the output so that the queue fills and the input backs up.
    initial
    begin
        hold_output = 1'b0;
        wait (sent_count >= 400);
        hold_output = 1'b1;
        repeat (150) @(posedge clk);
        hold_output = 1'b0;
    end

    initial
    begin
        logic [31:0] edge_vals[$];
        int          run_len;
        board       = new();
        idle_cycles = 0;
        timed_out   = 1'b0;
        sent_count  = 0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        addend   = '0;
        is_last  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zeros of both signs, subnormals, extremes, infinities, NaNs,
        // cancellation to +0 and an overflow to infinity, in compensated mode.
        edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                      32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000, 32'h3380_0000,
                      32'h7F80_0000, 32'hFF80_0000, 32'h7FC1_2345, 32'hFFFF_FFFF};
        send_addend(32'h8000_0000, 1'b0);
        send_addend(32'h8000_0000, 1'b1);
        send_addend(32'h3F80_0000, 1'b0);
        send_addend(32'hBF80_0000, 1'b1);
        foreach (edge_vals[i])
            send_addend(edge_vals[i], (i % 2) == 1);
        send_addend(32'h4B80_0000, 1'b0);
        send_addend(32'h3F80_0000, 1'b0);
        send_addend(32'h3F80_0000, 1'b1);
        drain();
        // Plain mode, then a mode change inside a run that keeps the error term.
        write_mode(cfsu_pkg::MODE_PLAIN);
        send_addend(32'h4B80_0000, 1'b0);
        send_addend(32'h3F80_0000, 1'b1);
        drain();
        write_mode(cfsu_pkg::MODE_COMP);
        send_addend(32'h4B80_0000, 1'b0);
        send_addend(32'h3F80_0000, 1'b0);
        drain();
        write_mode(cfsu_pkg::MODE_PLAIN);
        send_addend(32'h3F80_0000, 1'b1);
        drain();

        // Random runs of mostly short length, in several mode phases.
        for (int phase = 0; phase < 6; phase++)
        begin
            write_mode(phase % 2 == 0 ? cfsu_pkg::MODE_COMP : cfsu_pkg::MODE_PLAIN);
            for (int n = 0; n < 215; n++)
            begin
                run_len = $urandom_range(0, 5);
                send_addend(pick_value(), run_len == 0);
            end
            send_addend(pick_value(), 1'b1);
            drain();
        end

        drain();
        $display("Summary: %0d addends sent, %0d run totals checked in both modes.",
                 sent_count, board.totals_seen);
        if (board.mismatches == 0 && !timed_out)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire
